>>> design/evcs_pkg.sv
// Shared types and codes of the EV charging session controller.
package evcs_pkg;

	// Session states, encoded as they appear on the result stream
	typedef enum logic [3:0] {
		ST_IDLE       = 4'd0,
		ST_PLUG_IN    = 4'd1,
		ST_HANDSHAKE  = 4'd2,
		ST_AWAIT_LOCK = 4'd3,
		ST_AWAIT_INS  = 4'd4,
		ST_TRANSFER   = 4'd5,
		ST_WINDING    = 4'd6,
		ST_INHIBITED  = 4'd7,
		ST_ERROR      = 4'd8
	} state_t;

	// Event codes
	localparam logic [3:0] EV_PLUG_IN     = 4'd0;
	localparam logic [3:0] EV_PLUG_OUT    = 4'd1;
	localparam logic [3:0] EV_BMS_UPDATE  = 4'd2;
	localparam logic [3:0] EV_BMS_TIMEOUT = 4'd3;
	localparam logic [3:0] EV_INHIBIT_ON  = 4'd4;
	localparam logic [3:0] EV_INHIBIT_OFF = 4'd5;
	localparam logic [3:0] EV_STN_TIMEOUT = 4'd6;
	localparam logic [3:0] EV_IN1_ON      = 4'd7;
	localparam logic [3:0] EV_IN1_OFF     = 4'd8;
	localparam logic [3:0] EV_IN2_ON      = 4'd9;
	localparam logic [3:0] EV_STN_CAPS    = 4'd10;
	localparam logic [3:0] EV_STN_STATUS  = 4'd11;

	// Action strobe bit positions
	localparam int ACT_W          = 18;
	localparam int A_STOP_DIG     = 0;
	localparam int A_STOP_DISC    = 1;
	localparam int A_GO_DIG       = 2;
	localparam int A_GO_DISC      = 3;
	localparam int A_CAN_ON       = 4;
	localparam int A_CAN_OFF      = 5;
	localparam int A_OUT1_ON      = 6;
	localparam int A_OUT1_OFF     = 7;
	localparam int A_LIVE_ON      = 8;
	localparam int A_STN_REINIT   = 9;
	localparam int A_SES_REINIT   = 10;
	localparam int A_VMAX_UPD     = 11;
	localparam int A_CONT_PERMIT  = 12;
	localparam int A_CONT_INHIB   = 13;
	localparam int A_CUR_RECALC   = 14;
	localparam int A_TIME_RECALC  = 15;
	localparam int A_DEV_CHECK    = 16;
	localparam int A_RAMP_DOWN    = 17;

	// Stream widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	localparam logic [7:0] TERM_CUR_RESET = 8'd2;

endpackage

>>> design/ev_charge_session_fsm_top.sv
// EV charging session controller: event register, next-state logic, result register.
//
// Usage:
//   s_* carries one event request: s_tuser is the event code, s_tdata the
//   snapshot of battery, inhibit, plug and station flags plus station current.
//   m_* returns one result per event: new session state, action strobes and
//   the invalid-event flag.
//   cfg_* writes the termination current (8 bits); cfg_ready is always high.
//   Write it only while no event is in flight.
// Pipeline: an accepted event passes two register stages, the event register
//   and then the result register, before its result shows on m_*.
// Throughput: one event per cycle while m_tready stays high. The session
//   state register is updated when an event moves from the event register
//   to the result register, so the next event sees it in the following cycle.
// Stall: when m_tready is low the result holds; the event register still
//   takes one more request, after which s_tready drops until the result
//   is taken.
// Reset: arst_n clears both stages, returns the session to idle and the
//   termination current to 2 A.
module ev_charge_session_fsm_top
	import evcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data,    // termination current threshold
	// event stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [2:0] battery_flags, [3] inhibit_line, [4] plug_present,
	// [5] station_voltage_ok, [6] params_complete, [9:7] station_faults,
	// [10] station_allows_charge, [11] connector_locked,
	// [19:12] station_current, [23:20] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [3:0]            s_tuser,     // [3:0] func
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [3:0] session_state, [21:4] action_strobes, [22] invalid_event, [23] zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// stage 1: event register
	logic             valid_s1;
	logic [3:0]       func_s1;
	logic [2:0]       bat_s1;
	logic             inh_s1;
	logic             plug_s1;
	logic             volt_s1;
	logic             params_s1;
	logic [2:0]       faults_s1;
	logic             allow_s1;
	logic             locked_s1;
	logic [7:0]       cur_s1;

	// stage 2: result register
	logic             valid_s2;
	state_t           state_s2;
	logic [ACT_W-1:0] act_s2;
	logic             bad_s2;

	logic [7:0]       term_cur_q;
	state_t           state_q;

	logic             adv_s1;
	state_t           nxt_state;
	logic [ACT_W-1:0] nxt_act;
	logic             nxt_bad;

	assign adv_s1    = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_cur_q <= TERM_CUR_RESET;
		end else if (cfg_valid) begin
			term_cur_q <= cfg_data;
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1   <= s_tuser;
			bat_s1    <= s_tdata[2:0];
			inh_s1    <= s_tdata[3];
			plug_s1   <= s_tdata[4];
			volt_s1   <= s_tdata[5];
			params_s1 <= s_tdata[6];
			faults_s1 <= s_tdata[9:7];
			allow_s1  <= s_tdata[10];
			locked_s1 <= s_tdata[11];
			cur_s1    <= s_tdata[19:12];
		end
	end

	// next-state and action decode
	always_comb begin
		nxt_state = state_q;
		nxt_act   = '0;
		nxt_bad   = 1'b0;
		unique case (state_q)
			ST_PLUG_IN: begin
				unique case (func_s1)
					EV_BMS_UPDATE: begin
						nxt_act[A_VMAX_UPD] = 1'b1;
						if (bat_s1 != 3'd0) nxt_state = ST_INHIBITED;
					end
					EV_BMS_TIMEOUT: nxt_state = ST_ERROR;
					EV_IN1_ON: begin
						nxt_act[A_STN_REINIT] = 1'b1;
						nxt_act[A_CAN_ON]     = 1'b1;
						nxt_act[A_OUT1_ON]    = 1'b1;
						nxt_act[A_LIVE_ON]    = 1'b1;
						nxt_state = ST_HANDSHAKE;
					end
					EV_PLUG_OUT: begin
						nxt_act[A_SES_REINIT] = 1'b1;
						nxt_state = ST_IDLE;
					end
					EV_INHIBIT_ON:  nxt_state = ST_INHIBITED;
					EV_STN_TIMEOUT: ;
					default:        nxt_bad = 1'b1;
				endcase
			end
			ST_HANDSHAKE: begin
				unique case (func_s1)
					EV_IN1_OFF: begin
						nxt_act[A_STOP_DIG] = 1'b1;
						nxt_state = ST_PLUG_IN;
					end
					EV_BMS_UPDATE:  if (bat_s1 != 3'd0) nxt_state = ST_INHIBITED;
					EV_BMS_TIMEOUT: nxt_state = ST_ERROR;
					EV_STN_CAPS: begin
						priority if (!volt_s1) begin
							nxt_act[A_STOP_DIG] = 1'b1;
							nxt_state = ST_ERROR;
						end else if (params_s1) begin
							nxt_act[A_GO_DIG]  = 1'b1;
							nxt_act[A_GO_DISC] = 1'b1;
							nxt_state = ST_AWAIT_LOCK;
						end
					end
					EV_STN_STATUS: begin
						priority if (faults_s1 != 3'd0) begin
							nxt_act[A_CAN_OFF] = 1'b1;
							nxt_state = ST_ERROR;
						end else if (params_s1) begin
							nxt_act[A_GO_DIG]  = 1'b1;
							nxt_act[A_GO_DISC] = 1'b1;
							nxt_state = ST_AWAIT_LOCK;
						end
					end
					EV_PLUG_OUT: begin
						nxt_act[A_SES_REINIT] = 1'b1;
						nxt_state = ST_IDLE;
					end
					EV_INHIBIT_ON:  nxt_state = ST_INHIBITED;
					EV_STN_TIMEOUT: ;
					default:        nxt_bad = 1'b1;
				endcase
			end
			ST_AWAIT_LOCK: begin
				unique case (func_s1)
					EV_IN1_OFF: begin
						nxt_act[A_STOP_DIG] = 1'b1;
						nxt_state = ST_PLUG_IN;
					end
					EV_BMS_UPDATE:  if (bat_s1 != 3'd0) nxt_state = ST_INHIBITED;
					EV_BMS_TIMEOUT: nxt_state = ST_ERROR;
					EV_STN_CAPS:    ;
					EV_STN_STATUS: begin
						priority if (faults_s1 != 3'd0) begin
							nxt_act[A_CAN_OFF] = 1'b1;
							nxt_state = ST_ERROR;
						end else if (locked_s1) begin
							nxt_state = ST_AWAIT_INS;
						end
					end
					EV_PLUG_OUT: begin
						nxt_act[A_STOP_DIG]   = 1'b1;
						nxt_act[A_SES_REINIT] = 1'b1;
						nxt_state = ST_IDLE;
					end
					EV_INHIBIT_ON: begin
						nxt_act[A_OUT1_OFF] = 1'b1;
						nxt_state = ST_INHIBITED;
					end
					EV_STN_TIMEOUT: nxt_state = ST_ERROR;
					default:        nxt_bad = 1'b1;
				endcase
			end
			ST_AWAIT_INS: begin
				unique case (func_s1)
					EV_IN1_OFF: begin
						nxt_act[A_STOP_DIG] = 1'b1;
						nxt_state = ST_PLUG_IN;
					end
					EV_BMS_UPDATE: begin
						if (bat_s1 != 3'd0) begin
							nxt_act[A_STOP_DIG] = 1'b1;
							nxt_state = ST_INHIBITED;
						end
					end
					EV_BMS_TIMEOUT: begin
						nxt_act[A_STOP_DIG] = 1'b1;
						nxt_state = ST_ERROR;
					end
					EV_IN2_ON: begin
						nxt_act[A_CONT_PERMIT] = 1'b1;
						nxt_state = ST_TRANSFER;
					end
					EV_PLUG_OUT: begin
						nxt_act[A_SES_REINIT] = 1'b1;
						nxt_act[A_STOP_DIG]   = 1'b1;
						nxt_state = ST_IDLE;
					end
					EV_STN_CAPS: ;
					EV_STN_STATUS: begin
						if (faults_s1 != 3'd0) begin
							nxt_act[A_STOP_DIG] = 1'b1;
							nxt_state = ST_ERROR;
						end
					end
					EV_INHIBIT_ON: begin
						nxt_act[A_STOP_DIG] = 1'b1;
						nxt_state = ST_INHIBITED;
					end
					EV_STN_TIMEOUT: begin
						nxt_act[A_STOP_DIG] = 1'b1;
						nxt_state = ST_ERROR;
					end
					default: nxt_bad = 1'b1;
				endcase
			end
			ST_TRANSFER: begin
				unique case (func_s1)
					EV_BMS_UPDATE: begin
						// full: stop only; too hot: stop and still recalc current
						priority if (bat_s1[0]) begin
							nxt_act[A_STOP_DIG] = 1'b1;
							nxt_state = ST_WINDING;
						end else if (bat_s1[1]) begin
							nxt_act[A_STOP_DIG]   = 1'b1;
							nxt_act[A_CUR_RECALC] = 1'b1;
							nxt_state = ST_WINDING;
						end else begin
							nxt_act[A_CUR_RECALC] = 1'b1;
						end
					end
					EV_BMS_TIMEOUT: nxt_state = ST_ERROR;
					EV_PLUG_OUT: begin
						nxt_act[A_SES_REINIT] = 1'b1;
						nxt_state = ST_IDLE;
					end
					EV_STN_CAPS: begin
						nxt_act[A_CUR_RECALC]  = 1'b1;
						nxt_act[A_TIME_RECALC] = 1'b1;
					end
					EV_STN_STATUS: begin
						// refusal without a fault still runs the deviation check
						priority if (faults_s1 != 3'd0) begin
							nxt_act[A_STOP_DIG] = 1'b1;
							nxt_state = ST_WINDING;
						end else if (!allow_s1) begin
							nxt_act[A_STOP_DIG]  = 1'b1;
							nxt_act[A_DEV_CHECK] = 1'b1;
							nxt_state = ST_WINDING;
						end else begin
							nxt_act[A_DEV_CHECK] = 1'b1;
						end
					end
					EV_INHIBIT_ON: begin
						nxt_act[A_STOP_DIG] = 1'b1;
						nxt_state = ST_WINDING;
					end
					EV_STN_TIMEOUT: begin
						nxt_act[A_STOP_DIG] = 1'b1;
						nxt_state = ST_ERROR;
					end
					default: nxt_bad = 1'b1;
				endcase
			end
			ST_WINDING: begin
				// ramp down on every event, handled or not
				nxt_act[A_RAMP_DOWN] = 1'b1;
				unique case (func_s1)
					EV_STN_STATUS: begin
						if (cur_s1 <= term_cur_q) begin
							nxt_act[A_STOP_DISC]  = 1'b1;
							nxt_act[A_CONT_INHIB] = 1'b1;
						end
					end
					EV_PLUG_OUT, EV_BMS_UPDATE, EV_BMS_TIMEOUT, EV_INHIBIT_ON,
					EV_STN_TIMEOUT, EV_STN_CAPS: ;
					default: nxt_bad = 1'b1;
				endcase
			end
			ST_INHIBITED: begin
				unique case (func_s1)
					EV_BMS_UPDATE, EV_INHIBIT_OFF: begin
						if (bat_s1 == 3'd0 && !inh_s1)
							nxt_state = plug_s1 ? ST_PLUG_IN : ST_IDLE;
					end
					EV_BMS_TIMEOUT, EV_STN_TIMEOUT: nxt_state = ST_ERROR;
					EV_PLUG_IN: ;
					default:    nxt_bad = 1'b1;
				endcase
			end
			ST_ERROR: begin
				unique case (func_s1)
					EV_BMS_UPDATE: ;
					EV_PLUG_OUT: begin
						nxt_act[A_SES_REINIT] = 1'b1;
						nxt_state = ST_IDLE;
					end
					default: nxt_bad = 1'b1;
				endcase
			end
			default: begin
				// idle, and any unused code
				unique case (func_s1)
					EV_PLUG_IN: nxt_state = ST_PLUG_IN;
					EV_BMS_UPDATE: begin
						nxt_act[A_VMAX_UPD] = 1'b1;
						if (bat_s1 != 3'd0) nxt_state = ST_INHIBITED;
					end
					EV_BMS_TIMEOUT: nxt_state = ST_ERROR;
					EV_INHIBIT_ON: begin
						nxt_act[A_STOP_DIG] = 1'b1;
						nxt_state = ST_INHIBITED;
					end
					EV_STN_TIMEOUT: ;
					default:        nxt_bad = 1'b1;
				endcase
			end
		endcase
	end

	// session state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= nxt_state;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			state_s2 <= nxt_state;
			act_s2   <= nxt_act;
			bad_s2   <= nxt_bad;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, bad_s2, act_s2, state_s2};

	// the held result always reflects the live session state
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> state_q == state_s2)
		else $error("session state differs from pending result");

	// event codes past the last defined one are never handled
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && func_s1 > EV_STN_STATUS) |=> bad_s2)
		else $error("undefined event code not flagged invalid");

	// an invalid event fires no strobe, except ramp down while winding down
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && bad_s2) |-> (act_s2 == '0 ||
			(state_s2 == ST_WINDING && act_s2 == ACT_W'(1) << A_RAMP_DOWN)))
		else $error("strobes set on an invalid event");

	// an invalid event leaves the state where it was
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && nxt_bad) |=> state_q == $past(state_q))
		else $error("invalid event changed the session state");

endmodule
